### sv/autorange_seven_segment_scanner_core_assert.svh
// Assertion macros shared by the display scanner modules.
`ifndef AUTORANGE_SEVEN_SEGMENT_SCANNER_CORE_ASSERT_SVH
`define AUTORANGE_SEVEN_SEGMENT_SCANNER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define A7SEG_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define A7SEG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define A7SEG_ASSERT_ALWAYS(lbl, cond, msg)
`define A7SEG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/a7seg_pkg.sv
// Types, constants and the segment table of the display scanner.
package a7seg_pkg;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [31:0] LIMIT_E4 = 32'd10000;
  localparam logic [31:0] LIMIT_E5 = 32'd100000;
  localparam logic [31:0] LIMIT_E6 = 32'd1000000;
  localparam logic [31:0] LIMIT_E7 = 32'd10000000;

  localparam logic [1:0] DOT_AT_0 = 2'd0;
  localparam logic [1:0] DOT_AT_1 = 2'd1;
  localparam logic [1:0] DOT_AT_2 = 2'd2;
  localparam logic [1:0] DOT_AT_3 = 2'd3;

  // Multiplier for an exact divide by ten of any 32-bit value, with a shift of 35.
  localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [7:0] DOT_CLEAR_MASK = 8'hEF;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
  } item_t;

  typedef struct packed {
    logic [3:0] digit_enable;
    logic [7:0] segment_levels;
  } result_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] value;
    logic [1:0]  dot_pos;
  } qent_t;

  function automatic logic [7:0] seg_levels(input logic [3:0] digit);
    logic [7:0] lv;
    unique case (digit)
      4'd0:    lv = 8'd24;
      4'd1:    lv = 8'd187;
      4'd2:    lv = 8'd82;
      4'd3:    lv = 8'd146;
      4'd4:    lv = 8'd177;
      4'd5:    lv = 8'd148;
      4'd6:    lv = 8'd20;
      4'd7:    lv = 8'd186;
      4'd8:    lv = 8'd16;
      4'd9:    lv = 8'd144;
      default: lv = 8'd0;
    endcase
    return lv;
  endfunction

endpackage

### sv/autorange_seven_segment_scanner_core.sv
// Top level of the four-digit seven-segment scanner with an autoranging dot.
//
// The item channel (item_valid, item_stall, item) carries beats of two kinds.
// A load beat holds a value; values below ten million are turned into four
// decimal digits with the dot placed by range; others are dropped.
// A tick beat drives the next digit of the scan and yields one result beat
// on the result channel (result_valid, result_stall, result): a one-hot digit
// enable and active-low segment levels. Loads yield no result beat.
// Beats pass a front register, a two-entry queue and the back end in order,
// so a tick always shows every load accepted before it.
// The result beat of a tick is registered. Throughput: ticks run one per cycle
// while result_stall is low and no load is converting. A load holds the back
// end for the dequeue, then four digit steps plus one per dot position,
// set by the single divide-by-ten multiplier that yields one digit per cycle.
// The front keeps accepting beats until the queue and front register are full.
// Reset clears the stored digits to zero and the scan index to digit 0.
// While result_stall is high the result beat holds; further ticks wait in the
// queue and item_stall rises once the queue and front register are full.
module autorange_seven_segment_scanner_core import a7seg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic  push;
  qent_t entry;
  logic  full;
  logic  pop;
  qent_t head;
  logic  empty;

  a7seg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .entry      (entry),
    .full       (full)
  );

  a7seg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .full  (full),
    .pop   (pop),
    .head  (head),
    .empty (empty)
  );

  a7seg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### sv/a7seg_front.sv
// Front stage: accepts input beats, drops out-of-range loads and picks the dot position.
module a7seg_front import a7seg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  output logic  push,
  output qent_t entry,
  input  logic  full
);

  logic  f_valid;
  logic  f_valid_next;
  qent_t f_entry;
  logic  accept;
  logic  keep;
  logic [1:0] dot;

  assign item_stall = f_valid && full;
  assign push       = f_valid && !full;
  assign entry      = f_entry;
  assign accept     = item_valid && !item_stall;
  assign keep       = (item.kind == KIND_TICK) || (item.value < LIMIT_E7);

  always_comb begin
    priority if (item.value < LIMIT_E4) begin
      dot = DOT_AT_0;
    end else if (item.value < LIMIT_E5) begin
      dot = DOT_AT_1;
    end else if (item.value < LIMIT_E6) begin
      dot = DOT_AT_2;
    end else begin
      dot = DOT_AT_3;
    end
  end

  always_comb begin
    f_valid_next = f_valid;
    if (accept) begin
      f_valid_next = keep;
    end else if (push) begin
      f_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_entry.kind    <= item.kind;
      f_entry.value   <= item.value[23:0];
      f_entry.dot_pos <= dot;
    end
  end

endmodule

### sv/a7seg_queue.sv
// Two-entry queue between the front stage and the back end.
`include "autorange_seven_segment_scanner_core_assert.svh"
module a7seg_queue import a7seg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t entry,
  output logic  full,
  input  logic  pop,
  output qent_t head,
  output logic  empty
);

  qent_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  `A7SEG_ASSERT_ALWAYS(q_count_bound, count != 2'd3, "queue count out of range")
  `A7SEG_ASSERT_ALWAYS(q_no_overflow, !(push && full), "push into a full queue")
  `A7SEG_ASSERT_ALWAYS(q_no_underflow, !(pop && empty), "pop from an empty queue")

endmodule

### sv/a7seg_back.sv
// Back end: converts loads into stored digits and turns ticks into display beats.
`include "autorange_seven_segment_scanner_core_assert.svh"
module a7seg_back import a7seg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  qent_t   head,
  input  logic    empty,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [4:0]  digit_store [4];
  logic [1:0]  scan_index;
  logic        busy;
  logic [23:0] x;
  logic [2:0]  step;
  logic [1:0]  dot_pos;
  logic        out_free;
  logic        tick_pop;
  logic        load_pop;
  logic [55:0] prod;
  logic [20:0] quot;
  logic [23:0] quot_ten;
  logic [3:0]  digit;
  logic [2:0]  rel;
  logic [1:0]  pos;
  logic        write_en;
  logic        last_step;
  logic [4:0]  code;
  logic        dot;
  logic [3:0]  shown;
  logic [7:0]  levels;

  assign out_free = !result_valid || !result_stall;
  assign pop      = !empty && !busy && ((head.kind == KIND_LOAD) || out_free);
  assign tick_pop = pop && (head.kind == KIND_TICK);
  assign load_pop = pop && (head.kind == KIND_LOAD);

  assign prod      = 56'(x) * 56'(RECIP_TEN);
  assign quot      = prod[55:RECIP_SHIFT];
  assign quot_ten  = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign digit     = 4'(x - quot_ten);
  assign rel       = step - {1'b0, dot_pos};
  assign pos       = 2'd3 - rel[1:0];
  assign write_en  = busy && (step >= {1'b0, dot_pos});
  assign last_step = busy && (rel == 3'd3);

  always_comb begin
    code  = digit_store[scan_index];
    dot   = 1'b0;
    shown = code[3:0];
    if (code > 5'd9) begin
      dot   = 1'b1;
      shown = 4'(code - 5'd10);
    end
    levels = (code > 5'd19) ? 8'd0 : seg_levels(shown);
    if (dot) begin
      levels = levels & DOT_CLEAR_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      step         <= 3'd0;
      scan_index   <= 2'd0;
      result_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        digit_store[i] <= 5'd0;
      end
    end else begin
      if (load_pop) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (last_step) begin
          busy <= 1'b0;
        end
      end
      if (write_en) begin
        digit_store[pos] <= {1'b0, digit} + ((pos == dot_pos) ? 5'd10 : 5'd0);
      end
      if (tick_pop) begin
        scan_index   <= scan_index + 2'd1;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_pop) begin
      x       <= head.value;
      dot_pos <= head.dot_pos;
    end else if (busy) begin
      x <= 24'(quot);
    end
    if (tick_pop) begin
      result.digit_enable   <= 4'b0001 << scan_index;
      result.segment_levels <= levels;
    end
  end

  `A7SEG_ASSERT_ALWAYS(b_step_bound, !busy || (step <= 3'd6), "load conversion ran too long")
  `A7SEG_ASSERT_ALWAYS(b_tick_slot, !tick_pop || out_free, "tick taken while output blocked")
  `A7SEG_ASSERT_NEXT(b_load_ends, last_step, !busy, "load conversion did not finish")

endmodule

### tb/tb_autorange_seven_segment_scanner_core.sv
// Self-checking testbench of the seven-segment scanner: loads and scan ticks against a predictor.
module tb_autorange_seven_segment_scanner_core import a7seg_pkg::*;;

  localparam int RANDOM_ITEMS   = 1125;
  localparam int DRAIN_EVERY    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [7:0] SEG_PATTERN [10] = '{
    8'd24, 8'd187, 8'd82, 8'd146, 8'd177, 8'd148, 8'd20, 8'd186, 8'd16, 8'd144
  };

  class display_scoreboard;
    logic [4:0] digit_code [4];
    logic [1:0] scan_pos;
    result_t    scan_outputs_due [$];
    int         failures;

    function new();
      foreach (digit_code[i]) digit_code[i] = '0;
      scan_pos = '0;
      failures = 0;
    endfunction

    function void note_item(item_t beat);
      logic [31:0] kept;
      int          dot_at;
      int          pos;
      logic [4:0]  code;
      logic [4:0]  digit;
      result_t     want;
      if (beat.kind == KIND_LOAD) begin
        if (beat.value >= LIMIT_E7) return;
        if (beat.value < LIMIT_E4) begin
          kept = beat.value;
          dot_at = 0;
        end else if (beat.value < LIMIT_E5) begin
          kept = beat.value / 10;
          dot_at = 1;
        end else if (beat.value < LIMIT_E6) begin
          kept = beat.value / 100;
          dot_at = 2;
        end else begin
          kept = beat.value / 1000;
          dot_at = 3;
        end
        for (pos = 3; pos >= 0; pos--) begin
          digit_code[pos] = 5'(kept % 10) + ((pos == dot_at) ? 5'd10 : 5'd0);
          kept = kept / 10;
        end
        return;
      end
      code = digit_code[scan_pos];
      digit = (code > 5'd9) ? code - 5'd10 : code;
      want.digit_enable = 4'b0001 << scan_pos;
      want.segment_levels = (digit <= 5'd9) ? SEG_PATTERN[digit] : 8'd0;
      if (code > 5'd9) want.segment_levels = want.segment_levels & DOT_CLEAR_MASK;
      scan_outputs_due.push_back(want);
      scan_pos = scan_pos + 2'd1;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (scan_outputs_due.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("Unexpected scan beat: enable %b levels %h", got.digit_enable,
                   got.segment_levels);
        return;
      end
      want = scan_outputs_due.pop_front();
      if (got.digit_enable !== want.digit_enable ||
          got.segment_levels !== want.segment_levels) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("Scan beat mismatch: expected enable %b levels %h, got enable %b levels %h",
                   want.digit_enable, want.segment_levels, got.digit_enable,
                   got.segment_levels);
      end
    endfunction

    function void check_leftovers();
      if (scan_outputs_due.size() != 0) begin
        failures += scan_outputs_due.size();
        $display("Scan beats never delivered: %0d", scan_outputs_due.size());
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item_beat = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result_beat;

  display_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_run = 0;

  autorange_seven_segment_scanner_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item_beat);
      if (result_valid && !result_stall) sb.check_result(result_beat);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run = $urandom_range(5, 60);
    end
    stall_run = stall_run - 1;
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      2: result_stall <= ($urandom_range(0, 1) == 0);
      default: result_stall <= ((stall_run % 16) < 10);
    endcase
  end

  task automatic send_beat(item_t beat);
    item_beat <= beat;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic send_load(logic [31:0] value);
    item_t beat;
    beat.kind = KIND_LOAD;
    beat.value = value;
    send_beat(beat);
  endtask

  task automatic send_ticks(int count);
    item_t beat;
    repeat (count) begin
      beat.kind = KIND_TICK;
      beat.value = $urandom;
      send_beat(beat);
    end
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.scan_outputs_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 9999);
      1: return $urandom_range(10000, 99999);
      2: return $urandom_range(100000, 999999);
      3, 4: return $urandom_range(1000000, 9999999);
      5: begin
        case ($urandom_range(0, 8))
          0: return LIMIT_E4 - 1;
          1: return LIMIT_E4;
          2: return LIMIT_E5 - 1;
          3: return LIMIT_E5;
          4: return LIMIT_E6 - 1;
          5: return LIMIT_E6;
          6: return LIMIT_E7 - 1;
          7: return LIMIT_E7;
          default: return '0;
        endcase
      end
      6: return $urandom;
      default: return $urandom_range(0, 9999999);
    endcase
  endfunction

  task automatic run_directed();
    send_ticks(4);
    send_load(32'd9999);
    send_ticks(4);
    send_load(LIMIT_E4);
    send_load(32'hFFFF_FFFF);
    send_ticks(2);
    send_load(32'd999999);
    send_load(LIMIT_E7);
    send_ticks(2);
    send_load(LIMIT_E7 - 1);
    send_ticks(4);
    send_load(32'd0);
    send_ticks(2);
  endtask

  task automatic run_random();
    int    counted;
    int    burst_left;
    int    gap;
    int    next_drain;
    item_t beat;
    counted = 0;
    burst_left = 0;
    next_drain = DRAIN_EVERY;
    while (counted < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          item_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      beat.kind = ($urandom_range(0, 9) < 7) ? KIND_TICK : KIND_LOAD;
      beat.value = (beat.kind == KIND_TICK) ? $urandom : pick_value();
      send_beat(beat);
      burst_left--;
      if (!(beat.kind == KIND_LOAD && beat.value >= LIMIT_E7)) counted++;
      if (counted >= next_drain) begin
        wait_for_results();
        next_drain += DRAIN_EVERY;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    wait_for_results();
    run_random();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_leftovers();
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
